### hw/rtl/mcd_pkg.sv
// Package for the MACD indicator stream: widths, register indexes, the
// microcode word layout and the microcode program itself.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package mcd_pkg;

	localparam int PRICE_W = 32;
	localparam int COEF_F = 16;
	localparam int COEF_W = COEF_F + 1;
	localparam int LINE_W = PRICE_W + 1;
	localparam int HIST_W = PRICE_W + 2;
	localparam int OPND_W = PRICE_W + 2;
	localparam int PROD_W = OPND_W + COEF_W + 1;
	localparam int IN_DATA_W = ((PRICE_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = HIST_W + 2 * LINE_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W = 4;

	localparam logic [COEF_W-1:0] ONE_COEF = COEF_W'(1) << COEF_F;
	localparam logic [COEF_W-1:0] ALPHA_FAST_RST = COEF_W'(10082);
	localparam logic [COEF_W-1:0] ALPHA_SLOW_RST = COEF_W'(4855);
	localparam logic [COEF_W-1:0] ALPHA_SIGNAL_RST = COEF_W'(13107);
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_F - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA_FAST = 2'd0,
		REG_ALPHA_SLOW = 2'd1,
		REG_ALPHA_SIGNAL = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OPND_HOLD,
		OPND_X_FAST,
		OPND_X_SLOW,
		OPND_DIFF_SIG
	} opnd_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_FAST,
		ACC_SLOW_DIFF,
		ACC_SIGNAL,
		ACC_INIT
	} acc_sel_t;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_IF_START,
		JMP_WAIT_OUT,
		JMP_ALWAYS
	} jmp_t;

	localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] ST_LD_FAST = 4'd1;
	localparam logic [STEP_W-1:0] ST_LD_SLOW = 4'd2;
	localparam logic [STEP_W-1:0] ST_MUL_SLOW = 4'd3;
	localparam logic [STEP_W-1:0] ST_ACC_SLOW = 4'd4;
	localparam logic [STEP_W-1:0] ST_LD_SIG = 4'd5;
	localparam logic [STEP_W-1:0] ST_MUL_SIG = 4'd6;
	localparam logic [STEP_W-1:0] ST_ACC_SIG = 4'd7;
	localparam logic [STEP_W-1:0] ST_EMIT = 4'd8;
	localparam logic [STEP_W-1:0] ST_INIT = 4'd9;

	typedef struct packed {
		opnd_sel_t opnd;
		logic mul_en;
		acc_sel_t acc;
		logic emit;
		jmp_t jmp;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic ld_price;
		opnd_sel_t opnd;
		logic mul_en;
		acc_sel_t acc;
		logic emit;
	} dp_ctrl_t;

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{opnd: OPND_HOLD, mul_en: 1'b0, acc: ACC_NONE, emit: 1'b0,
			jmp: JMP_ALWAYS, target: ST_IDLE};
		case (step)
			ST_IDLE: begin
				w.jmp = JMP_WAIT_IN;
			end
			ST_LD_FAST: begin
				w.opnd = OPND_X_FAST;
				w.jmp = JMP_IF_START;
				w.target = ST_INIT;
			end
			ST_LD_SLOW: begin
				w.opnd = OPND_X_SLOW;
				w.mul_en = 1'b1;
				w.jmp = JMP_NEXT;
			end
			ST_MUL_SLOW: begin
				w.mul_en = 1'b1;
				w.acc = ACC_FAST;
				w.jmp = JMP_NEXT;
			end
			ST_ACC_SLOW: begin
				w.acc = ACC_SLOW_DIFF;
				w.jmp = JMP_NEXT;
			end
			ST_LD_SIG: begin
				w.opnd = OPND_DIFF_SIG;
				w.jmp = JMP_NEXT;
			end
			ST_MUL_SIG: begin
				w.mul_en = 1'b1;
				w.jmp = JMP_NEXT;
			end
			ST_ACC_SIG: begin
				w.acc = ACC_SIGNAL;
				w.jmp = JMP_NEXT;
			end
			ST_EMIT: begin
				w.emit = 1'b1;
				w.jmp = JMP_WAIT_OUT;
				w.target = ST_IDLE;
			end
			ST_INIT: begin
				w.acc = ACC_INIT;
				w.jmp = JMP_ALWAYS;
				w.target = ST_EMIT;
			end
			default: begin
				w.jmp = JMP_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mcd_sequencer.sv
// Microcode sequencer: step counter, program lookup and jump logic.
// Depends on mcd_pkg for the program and the control word types.
`default_nettype none

module mcd_sequencer
	import mcd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_start,
	input  wire logic     out_free,
	output logic          in_ready,
	output dp_ctrl_t      ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nx;
	logic              start_q;
	logic              in_fire;
	uword_t            uw;

	assign uw = ucode(step_q);
	assign in_ready = (uw.jmp == JMP_WAIT_IN);
	assign in_fire = in_ready && in_valid;

	always_comb begin
		step_nx = step_q;
		case (uw.jmp)
			JMP_NEXT: step_nx = step_q + STEP_W'(1);
			JMP_WAIT_IN: step_nx = in_fire ? step_q + STEP_W'(1) : step_q;
			JMP_IF_START: step_nx = start_q ? uw.target : step_q + STEP_W'(1);
			JMP_WAIT_OUT: step_nx = out_free ? uw.target : step_q;
			JMP_ALWAYS: step_nx = uw.target;
			default: step_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.ld_price = in_fire;
		ctrl.opnd = uw.opnd;
		ctrl.mul_en = uw.mul_en;
		ctrl.acc = uw.acc;
		ctrl.emit = uw.emit && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			step_q <= step_nx;
			if (in_fire) begin
				start_q <= in_start;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mcd_datapath.sv
// Datapath: operand registers, the shared multiplier with rounding, the three
// averages and the output register. Driven by control words from mcd_sequencer.
// Depends on mcd_pkg.
`default_nettype none

module mcd_datapath
	import mcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_ctrl_t          ctrl,
	input  wire logic [PRICE_W-1:0] price,
	input  wire logic [COEF_W-1:0] alpha_fast,
	input  wire logic [COEF_W-1:0] alpha_slow,
	input  wire logic [COEF_W-1:0] alpha_signal,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   out_free,
	output logic signed [HIST_W-1:0] histogram,
	output logic signed [LINE_W-1:0] diff_line,
	output logic signed [LINE_W-1:0] signal_line
);

	logic [PRICE_W-1:0]        price_q;
	logic [PRICE_W-1:0]        fast_q;
	logic [PRICE_W-1:0]        slow_q;
	logic signed [LINE_W-1:0]  sig_q;
	logic signed [LINE_W-1:0]  diff_q;
	logic signed [OPND_W-1:0]  opnd_q;
	logic [COEF_W-1:0]         coef_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      out_valid_q;
	logic signed [HIST_W-1:0]  hist_q;
	logic signed [LINE_W-1:0]  diff_out_q;
	logic signed [LINE_W-1:0]  sig_out_q;

	logic signed [OPND_W-1:0]  price_x;
	logic signed [OPND_W-1:0]  fast_x;
	logic signed [OPND_W-1:0]  slow_x;
	logic signed [OPND_W-1:0]  sig_x;
	logic signed [OPND_W-1:0]  diff_x;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [OPND_W-1:0]  step_d;
	logic signed [OPND_W-1:0]  fast_nx;
	logic signed [OPND_W-1:0]  slow_nx;
	logic signed [OPND_W-1:0]  sig_nx;
	logic signed [OPND_W-1:0]  diff_nx;
	logic signed [HIST_W-1:0]  hist_nx;

	assign price_x = signed'({2'b00, price_q});
	assign fast_x = signed'({2'b00, fast_q});
	assign slow_x = signed'({2'b00, slow_q});
	assign sig_x = OPND_W'(sig_q);
	assign diff_x = OPND_W'(diff_q);

	// Round to nearest with ties toward plus infinity, then drop the fraction.
	assign prod_rnd = prod_q + signed'(ROUND_HALF);
	assign step_d = prod_rnd[COEF_F +: OPND_W];

	assign fast_nx = fast_x + step_d;
	assign slow_nx = slow_x + step_d;
	assign sig_nx = sig_x + step_d;
	assign diff_nx = fast_x - slow_nx;
	assign hist_nx = HIST_W'(diff_q) - HIST_W'(sig_q);

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign histogram = hist_q;
	assign diff_line = diff_out_q;
	assign signal_line = sig_out_q;

	always_ff @(posedge clk) begin
		if (ctrl.ld_price) begin
			price_q <= price;
		end
		case (ctrl.opnd)
			OPND_X_FAST: begin
				opnd_q <= price_x - fast_x;
				coef_q <= alpha_fast;
			end
			OPND_X_SLOW: begin
				opnd_q <= price_x - slow_x;
				coef_q <= alpha_slow;
			end
			OPND_DIFF_SIG: begin
				opnd_q <= diff_x - sig_x;
				coef_q <= alpha_signal;
			end
			default: begin
			end
		endcase
		if (ctrl.mul_en) begin
			prod_q <= PROD_W'(opnd_q) * PROD_W'(signed'({1'b0, coef_q}));
		end
		case (ctrl.acc)
			ACC_SLOW_DIFF: diff_q <= diff_nx[LINE_W-1:0];
			ACC_INIT: diff_q <= '0;
			default: begin
			end
		endcase
		if (ctrl.emit) begin
			hist_q <= hist_nx;
			diff_out_q <= diff_q;
			sig_out_q <= sig_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= '0;
			slow_q <= '0;
			sig_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctrl.acc)
				ACC_FAST: fast_q <= fast_nx[PRICE_W-1:0];
				ACC_SLOW_DIFF: slow_q <= slow_nx[PRICE_W-1:0];
				ACC_SIGNAL: sig_q <= sig_nx[LINE_W-1:0];
				ACC_INIT: begin
					fast_q <= price_q;
					slow_q <= price_q;
					sig_q <= '0;
				end
				default: begin
				end
			endcase
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/macd_indicator_stream.sv
// Top level of the MACD indicator stream: coefficient registers, stream ports,
// and the sequencer and datapath. Depends on mcd_pkg, mcd_sequencer, mcd_datapath.
`default_nettype none

// One price sample per request gives one result of histogram, diff line and
// signal line. A sample is finished before the next one is taken, because the
// three average updates share a single multiplier and follow the program
// steps one after another; a sample that starts a series skips the multiplier
// steps and goes through the init step. A finished result waits in the output
// register, so the next sample is already processed while it is not taken, up
// to the emit step. Coefficients written above one are held at exactly one.
module macd_indicator_stream
	import mcd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // price
	input  wire logic [0:0]            s_tuser,  // series_start
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // histogram, diff_line, signal_line
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [COEF_W-1:0]     cfg_data
);

	logic [COEF_W-1:0]        alpha_fast_q;
	logic [COEF_W-1:0]        alpha_slow_q;
	logic [COEF_W-1:0]        alpha_signal_q;
	logic [COEF_W-1:0]        cfg_sat;
	dp_ctrl_t                 ctrl;
	logic                     out_free;
	logic signed [HIST_W-1:0] histogram;
	logic signed [LINE_W-1:0] diff_line;
	logic signed [LINE_W-1:0] signal_line;

	assign cfg_sat = (cfg_data > ONE_COEF) ? ONE_COEF : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_fast_q <= ALPHA_FAST_RST;
			alpha_slow_q <= ALPHA_SLOW_RST;
			alpha_signal_q <= ALPHA_SIGNAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA_FAST: alpha_fast_q <= cfg_sat;
				REG_ALPHA_SLOW: alpha_slow_q <= cfg_sat;
				REG_ALPHA_SIGNAL: alpha_signal_q <= cfg_sat;
				default: begin
				end
			endcase
		end
	end

	mcd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_start (s_tuser[0]),
		.out_free (out_free),
		.in_ready (s_tready),
		.ctrl     (ctrl)
	);

	mcd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.price        (s_tdata[PRICE_W-1:0]),
		.alpha_fast   (alpha_fast_q),
		.alpha_slow   (alpha_slow_q),
		.alpha_signal (alpha_signal_q),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_free     (out_free),
		.histogram    (histogram),
		.diff_line    (diff_line),
		.signal_line  (signal_line)
	);

	assign m_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), signal_line, diff_line, histogram};

`ifndef SYNTHESIS
	// A result is only written into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (!m_tvalid || m_tready))
		else $error("result written over a pending result");

	// Once a request is taken, the sequencer is busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while one is in progress");

	// Coefficients never exceed one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(alpha_fast_q <= ONE_COEF) && (alpha_slow_q <= ONE_COEF)
		&& (alpha_signal_q <= ONE_COEF))
		else $error("coefficient register above one");
`endif

endmodule

`default_nettype wire
